// ----- hdl/scu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package scu_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ANGLE_W   = 18;
    localparam int SINE_W    = 18;
    localparam int COS_W     = 17;
    localparam int TERM_W    = 18;
    localparam int X2_W      = 19;
    localparam int P_W       = 20;
    localparam int ACC_W     = 21;
    localparam int RECIP_W   = 14;
    localparam int ABS_W     = 17;
    localparam int ARG_W     = 34;
    localparam int ROOT_W    = 17;
    localparam int REM_W     = 21;

    localparam logic signed [ACC_W-1:0] ACC_ONE = 21'sh10000;
    localparam logic [ARG_W-1:0] ONE_SQ = 34'h1_0000_0000;

    // One series word in flight: sign of the angle, x^2, running sum, last term.
    typedef struct packed {
        logic                     neg;
        logic [X2_W-1:0]          x2;
        logic signed [ACC_W-1:0]  acc;
        logic [TERM_W-1:0]        term;
    } t_ser;

    // Rounded reciprocals of (2k)(2k+1) with 16 fraction bits.
    function automatic logic [RECIP_W-1:0] recip(input int k);
        logic [RECIP_W-1:0] v;
        case (k)
            1:       v = 14'd10923;
            2:       v = 14'd3277;
            3:       v = 14'd1560;
            4:       v = 14'd910;
            5:       v = 14'd596;
            6:       v = 14'd420;
            7:       v = 14'd312;
            8:       v = 14'd241;
            9:       v = 14'd192;
            10:      v = 14'd156;
            11:      v = 14'd130;
            12:      v = 14'd109;
            13:      v = 14'd93;
            14:      v = 14'd81;
            15:      v = 14'd70;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/sine_cosine_unit.sv -----
// Channel   Direction  Ports                       Handshake
// command   in         i_angle                     start high while busy low
// result    out        o_sine, o_cosine            o_valid high for one cycle
//
// Fully pipelined: a new angle is taken every cycle and busy stays low.
// The pipeline has two input stages, two per series step (multiply by x^2,
// then by the reciprocal), two for saturation and 1 - sine^2, and 17 for
// the square root, one bit each.
// Synchronous active-low reset clears only the valid bits.
// Results cannot be held off, so the pipeline never stalls.
`timescale 1ns / 1ps
`default_nettype none

module sine_cosine_unit #(
    parameter int MAX_TERMS = 8
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire signed [scu_pkg::ANGLE_W-1:0]   i_angle,
    output logic                                o_valid,
    output logic signed [scu_pkg::SINE_W-1:0]   o_sine,
    output logic [scu_pkg::COS_W-1:0]           o_cosine
);

    logic                                   r_v0;
    logic [scu_pkg::ANGLE_W-1:0]            r_angle;
    logic                                   w_v   [MAX_TERMS];
    scu_pkg::t_ser                          w_d   [MAX_TERMS];
    logic                                   r_v1;
    scu_pkg::t_ser                          r_s1;
    scu_pkg::t_ser                          n_s1;
    logic [scu_pkg::TERM_W-1:0]             w_mag;
    logic [2*scu_pkg::TERM_W-1:0]           w_sq;

    logic                                   r_vt1;
    logic [scu_pkg::SINE_W-1:0]             r_sine;
    logic [scu_pkg::ABS_W-1:0]              r_abs;
    logic signed [scu_pkg::ACC_W-1:0]       w_sgn;
    logic signed [scu_pkg::ACC_W-1:0]       w_sat;
    logic signed [scu_pkg::ACC_W-1:0]       w_abs;

    logic                                   r_vt2;
    logic [scu_pkg::SINE_W-1:0]             r_sine2;
    logic [scu_pkg::ARG_W-1:0]              r_arg;
    logic [2*scu_pkg::ABS_W-1:0]            w_abs_sq;

    logic [scu_pkg::SINE_W-1:0]             w_sine_out;

    assign busy = 1'b0;

    // Front end: magnitude, x^2 and the first term.
    assign w_mag = scu_pkg::TERM_W'(18'd0 - r_angle);
    always_comb begin
        n_s1.neg  = r_angle[scu_pkg::ANGLE_W-1];
        n_s1.term = n_s1.neg ? w_mag : r_angle;
        n_s1.acc  = signed'({{(scu_pkg::ACC_W-scu_pkg::TERM_W){1'b0}}, n_s1.term});
        w_sq      = {{scu_pkg::TERM_W{1'b0}}, n_s1.term}
                  * {{scu_pkg::TERM_W{1'b0}}, n_s1.term};
        n_s1.x2   = w_sq[scu_pkg::FRAC_BITS +: scu_pkg::X2_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= start;
            r_v1 <= r_v0;
        end
        r_angle <= i_angle;
        r_s1    <= n_s1;
    end

    assign w_v[0] = r_v1;
    assign w_d[0] = r_s1;

    // A term that reaches zero stays zero, so every step may simply run.
    for (genvar k = 1; k < MAX_TERMS; k++) begin : g_term
        scu_term #(
            .K (k)
        ) u_term (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[k-1]),
            .i_data  (w_d[k-1]),
            .o_valid (w_v[k]),
            .o_data  (w_d[k])
        );
    end

    // Apply the sign and saturate to plus or minus one.
    always_comb begin
        w_sgn = w_d[MAX_TERMS-1].neg ? -w_d[MAX_TERMS-1].acc : w_d[MAX_TERMS-1].acc;
        if (w_sgn > scu_pkg::ACC_ONE) begin
            w_sat = scu_pkg::ACC_ONE;
        end else if (w_sgn < -scu_pkg::ACC_ONE) begin
            w_sat = -scu_pkg::ACC_ONE;
        end else begin
            w_sat = w_sgn;
        end
        w_abs = (w_sat < 0) ? -w_sat : w_sat;
    end

    assign w_abs_sq = {{scu_pkg::ABS_W{1'b0}}, r_abs} * {{scu_pkg::ABS_W{1'b0}}, r_abs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vt1 <= 1'b0;
            r_vt2 <= 1'b0;
        end else begin
            r_vt1 <= w_v[MAX_TERMS-1];
            r_vt2 <= r_vt1;
        end
        r_sine  <= w_sat[scu_pkg::SINE_W-1:0];
        r_abs   <= w_abs[scu_pkg::ABS_W-1:0];
        r_sine2 <= r_sine;
        // The square never exceeds one, so the difference cannot go negative.
        r_arg   <= scu_pkg::ONE_SQ - w_abs_sq;
    end

    scu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vt2),
        .i_arg   (r_arg),
        .i_sine  (r_sine2),
        .o_valid (o_valid),
        .o_root  (o_cosine),
        .o_sine  (w_sine_out)
    );

    assign o_sine = signed'(w_sine_out);

endmodule

`default_nettype wire

// ----- hdl/scu_term.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scu_term #(
    parameter int K = 1
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire scu_pkg::t_ser  i_data,
    output logic                o_valid,
    output scu_pkg::t_ser       o_data
);

    localparam logic [scu_pkg::RECIP_W-1:0] RECIP = scu_pkg::recip(K);

    logic                                       r_va;
    logic                                       r_vb;
    scu_pkg::t_ser                              r_a;
    logic [scu_pkg::P_W-1:0]                    r_p;
    scu_pkg::t_ser                              r_b;
    logic [scu_pkg::P_W-1:0]                    n_p;
    scu_pkg::t_ser                              n_b;
    logic [scu_pkg::TERM_W+scu_pkg::X2_W-1:0]   w_prod1;
    logic [scu_pkg::P_W+scu_pkg::RECIP_W-1:0]   w_prod2;
    logic [scu_pkg::TERM_W-1:0]                 w_term;
    logic signed [scu_pkg::ACC_W-1:0]           w_term_s;

    assign w_prod1 = {{scu_pkg::X2_W{1'b0}}, i_data.term}
                   * {{scu_pkg::TERM_W{1'b0}}, i_data.x2};
    assign n_p     = w_prod1[scu_pkg::FRAC_BITS +: scu_pkg::P_W];

    assign w_prod2  = {{scu_pkg::RECIP_W{1'b0}}, r_p} * {{scu_pkg::P_W{1'b0}}, RECIP};
    assign w_term   = w_prod2[scu_pkg::FRAC_BITS +: scu_pkg::TERM_W];
    assign w_term_s = signed'({{(scu_pkg::ACC_W-scu_pkg::TERM_W){1'b0}}, w_term});

    // Odd steps subtract, even steps add.
    always_comb begin
        n_b      = r_a;
        n_b.term = w_term;
        if ((K % 2) == 1) begin
            n_b.acc = r_a.acc - w_term_s;
        end else begin
            n_b.acc = r_a.acc + w_term_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
        r_a <= i_data;
        r_p <= n_p;
        r_b <= n_b;
    end

    assign o_valid = r_vb;
    assign o_data  = r_b;

endmodule

`default_nettype wire

// ----- hdl/scu_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scu_sqrt (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    input  wire [scu_pkg::ARG_W-1:0]        i_arg,
    input  wire [scu_pkg::SINE_W-1:0]       i_sine,
    output logic                            o_valid,
    output logic [scu_pkg::ROOT_W-1:0]      o_root,
    output logic [scu_pkg::SINE_W-1:0]      o_sine
);

    localparam int N = scu_pkg::ROOT_W;

    logic                           w_v    [N+1];
    logic [scu_pkg::ARG_W-1:0]      w_arg  [N+1];
    logic [scu_pkg::REM_W-1:0]      w_rem  [N+1];
    logic [scu_pkg::ROOT_W-1:0]     w_root [N+1];
    logic [scu_pkg::SINE_W-1:0]     w_sine [N+1];

    assign w_v[0]    = i_valid;
    assign w_arg[0]  = i_arg;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_sine[0] = i_sine;

    // One result bit per stage, two argument bits brought down each time.
    for (genvar i = 0; i < N; i++) begin : g_stage
        logic                           r_v;
        logic [scu_pkg::ARG_W-1:0]      r_arg;
        logic [scu_pkg::REM_W-1:0]      r_rem;
        logic [scu_pkg::ROOT_W-1:0]     r_root;
        logic [scu_pkg::SINE_W-1:0]     r_sine;
        logic [scu_pkg::REM_W-1:0]      n_rem;
        logic [scu_pkg::ROOT_W-1:0]     n_root;
        logic [scu_pkg::REM_W-1:0]      w_cur;
        logic [scu_pkg::REM_W-1:0]      w_trial;

        assign w_cur   = {w_rem[i][scu_pkg::REM_W-3:0],
                          w_arg[i][scu_pkg::ARG_W-1 -: 2]};
        assign w_trial = {{(scu_pkg::REM_W-scu_pkg::ROOT_W-2){1'b0}}, w_root[i], 2'b01};

        always_comb begin
            if (w_cur >= w_trial) begin
                n_rem  = w_cur - w_trial;
                n_root = {w_root[i][scu_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = w_cur;
                n_root = {w_root[i][scu_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= w_v[i];
            end
            r_arg  <= {w_arg[i][scu_pkg::ARG_W-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
            r_sine <= w_sine[i];
        end

        assign w_v[i+1]    = r_v;
        assign w_arg[i+1]  = r_arg;
        assign w_rem[i+1]  = r_rem;
        assign w_root[i+1] = r_root;
        assign w_sine[i+1] = r_sine;
    end

    assign o_valid = w_v[N];
    assign o_root  = w_root[N];
    assign o_sine  = w_sine[N];

endmodule

`default_nettype wire
